[rtl/cspc_pkg.sv]
// ----------------------------------------------------------------------------
// Command stream phase checker package
// Opcodes, phase codes, diagnostic codes, result record and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cspc_pkg;

  // Default diagnostic limit and result queue depth.
  localparam int DIAG_LIMIT_DEF = 64;
  localparam int QUEUE_DEPTH    = 16;
  // Most results that one command byte can cause.
  localparam int MAX_RESULTS    = 6;
  // Diagnostic candidate slots: three from the opcode, two from the end checks.
  localparam int NUM_SLOTS      = 5;
  localparam int OP_SLOTS       = 3;

  // Check levels.
  localparam logic [1:0] LVL_SYNTAX = 2'd0;
  localparam logic [1:0] LVL_PHASE  = 2'd1;
  localparam logic [1:0] LVL_FULL   = 2'd2;

  // Opcodes.
  localparam logic [7:0] OP_NOP            = 8'h00;
  localparam logic [7:0] OP_BEGIN_STREAM   = 8'h01;
  localparam logic [7:0] OP_BARRIER        = 8'h02;
  localparam logic [7:0] OP_SUBMIT         = 8'h03;
  localparam logic [7:0] OP_FENCE_WAIT     = 8'h04;
  localparam logic [7:0] OP_END_STREAM     = 8'h05;
  localparam logic [7:0] OP_PROG_END       = 8'h06;
  localparam logic [7:0] OP_SNAPSHOT_BEGIN = 8'h07;
  localparam logic [7:0] OP_SNAPSHOT_END   = 8'h08;
  localparam logic [7:0] OP_CHECKPOINT     = 8'h09;

  // Phases.
  localparam logic [2:0] PH_BUILD     = 3'd0;
  localparam logic [2:0] PH_RECORD    = 3'd1;
  localparam logic [2:0] PH_SUBMITTED = 3'd2;
  localparam logic [2:0] PH_IDLE      = 3'd3;
  localparam logic [2:0] PH_FINISHED  = 3'd4;

  // Severity.
  localparam logic SEV_ERROR = 1'b0;
  localparam logic SEV_WARN  = 1'b1;

  // Diagnostic codes.
  localparam logic [4:0] DG_UNKNOWN_OP      = 5'd0;
  localparam logic [4:0] DG_BEGIN_SNAP      = 5'd1;
  localparam logic [4:0] DG_BEGIN_PHASE     = 5'd2;
  localparam logic [4:0] DG_BARRIER_PHASE   = 5'd3;
  localparam logic [4:0] DG_BARRIER_HOST    = 5'd4;
  localparam logic [4:0] DG_SUBMIT_PHASE    = 5'd5;
  localparam logic [4:0] DG_SUBMIT_SNAP     = 5'd6;
  localparam logic [4:0] DG_FENCE_PHASE     = 5'd7;
  localparam logic [4:0] DG_ENDSTR_PHASE    = 5'd8;
  localparam logic [4:0] DG_ENDSTR_RECORD   = 5'd9;
  localparam logic [4:0] DG_ENDPRG_PHASE    = 5'd10;
  localparam logic [4:0] DG_ENDPRG_NOTLAST  = 5'd11;
  localparam logic [4:0] DG_SNAP_NESTED     = 5'd12;
  localparam logic [4:0] DG_SNAP_PHASE      = 5'd13;
  localparam logic [4:0] DG_SNAP_DEVICE     = 5'd14;
  localparam logic [4:0] DG_SNAPEND_NONE    = 5'd15;
  localparam logic [4:0] DG_CKPT_PHASE      = 5'd16;
  localparam logic [4:0] DG_UNTERM_SNAP     = 5'd17;
  localparam logic [4:0] DG_MISS_ENDSTR     = 5'd18;
  localparam logic [4:0] DG_MISS_ENDPRG     = 5'd19;
  localparam logic [4:0] DG_UNTERM_PROG     = 5'd20;

  // One diagnostic candidate.
  typedef struct packed {
    logic       valid;
    logic [4:0] code;
    logic       sev;
  } diag_t;

  // One result record as held in the queue.
  typedef struct packed {
    logic [4:0]  diag_code;
    logic        severity;
    logic [15:0] instr_index;
    logic [2:0]  phase_seen;
    logic        is_summary;
    logic        success;
    logic [15:0] error_total;
    logic [15:0] warning_total;
    logic [15:0] known_count;
    logic [15:0] dropped_total;
    logic        last;
  } res_t;

  // Saturating add of a small count to a 16-bit counter.
  function automatic logic [15:0] sat_add16(input logic [15:0] v, input logic [2:0] n);
    logic [16:0] s;
    s = {1'b0, v} + 17'(n);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/command_stream_phase_checker.sv]
// A command byte is registered, checked in the next cycle, and its results are
// written into the result queue, from which they are offered.
// Throughput: one byte per cycle while the 16-entry result queue has room for the
// bursts in flight; results leave one per cycle while out_tready is high.
// Reset (rst_n low, synchronous) returns all phase state and counters to zero,
// empties the queue and sets the check level to 2.
// ----------------------------------------------------------------------------
// Command stream phase checker
// Checks opcode order against a five-phase machine and emits numbered
// diagnostics and a final summary result through a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module command_stream_phase_checker #(
  parameter int DIAG_LIMIT = cspc_pkg::DIAG_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: check_level.
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  // Command bytes. tdata: opcode[7:0]. tlast: is_last.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  // Results. tdata: diag_code[4:0], severity[5], instr_index[21:6],
  // phase_seen[24:22], success[25], error_total[41:26], warning_total[57:42],
  // known_count[73:58], dropped_total[89:74], zero fill[95:90].
  // tuser: is_summary. tlast: last.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  // The emit counter is at least three bits wide so that a slot count fits.
  localparam int EMW   = ($clog2(DIAG_LIMIT + 1) > 3) ? $clog2(DIAG_LIMIT + 1) : 3;
  localparam int DEPTH = cspc_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NS    = cspc_pkg::NUM_SLOTS;
  localparam int NR    = cspc_pkg::MAX_RESULTS;

  localparam logic [EMW-1:0] LIMIT_V = EMW'(DIAG_LIMIT);

  // Configuration register.
  logic [1:0] level_r;

  // Input register.
  logic       stg_v_r;
  logic [7:0] stg_op_r;
  logic       stg_last_r;

  // Checker state.
  logic [2:0]     phase_r, phase_nxt;
  logic           dev_r, dev_nxt;
  logic           snap_r, snap_nxt;
  logic           seen_se_r, seen_se_nxt;
  logic           seen_pe_r, seen_pe_nxt;
  logic           stopped_r, stopped_nxt;
  logic [15:0]    index_r, index_nxt;
  logic [15:0]    known_r, known_nxt;
  logic [15:0]    err_r, err_nxt;
  logic [15:0]    warn_r, warn_nxt;
  logic [EMW-1:0] emit_cnt_r, emit_cnt_nxt;
  logic [15:0]    drop_r, drop_nxt;

  // Result queue.
  cspc_pkg::res_t queue_r [DEPTH];
  logic [PW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  count_r;

  // Processing signals.
  logic                proc;
  logic                p1, p2;
  logic                known_op;
  logic                end_run;
  cspc_pkg::diag_t     slot [NS];
  logic [EMW-1:0]      avail_full;
  logic [2:0]          avail;
  logic [2:0]          rank;
  logic [2:0]          n_err, n_warn, n_drop;
  logic [NS-1:0]       emit;
  logic [2:0]          pos [NS];
  logic [2:0]          nres;
  cspc_pkg::res_t      rec [NS];
  cspc_pkg::res_t      sum_rec;
  logic [PW-1:0]       waddr [NS];
  logic [PW-1:0]       sum_addr;
  logic                pop;

  assign proc = stg_v_r && !stopped_r;
  assign p1   = level_r >= cspc_pkg::LVL_PHASE;
  assign p2   = level_r >= cspc_pkg::LVL_FULL;
  assign pop  = out_tvalid && out_tready;

  // Room for a full burst behind the one already in the input register.
  assign in_tready = (32'(count_r) + (stg_v_r ? NR : 0)) <= (DEPTH - NR);

  // Opcode checks and phase machine update.
  always_comb begin
    phase_nxt   = phase_r;
    dev_nxt     = dev_r;
    snap_nxt    = snap_r;
    seen_se_nxt = seen_se_r;
    seen_pe_nxt = seen_pe_r;
    stopped_nxt = stopped_r;
    for (int k = 0; k < NS; k++) begin
      slot[k] = '0;
    end
    known_op = stg_op_r <= cspc_pkg::OP_CHECKPOINT;
    if (!known_op) begin
      slot[0] = '{1'b1, cspc_pkg::DG_UNKNOWN_OP, cspc_pkg::SEV_ERROR};
    end else begin
      case (stg_op_r)
        cspc_pkg::OP_BEGIN_STREAM: begin
          slot[0] = '{p1 && snap_r, cspc_pkg::DG_BEGIN_SNAP, cspc_pkg::SEV_ERROR};
          slot[1] = '{p1 && phase_r != cspc_pkg::PH_BUILD && phase_r != cspc_pkg::PH_IDLE,
                      cspc_pkg::DG_BEGIN_PHASE, cspc_pkg::SEV_ERROR};
          phase_nxt = cspc_pkg::PH_RECORD;
        end
        cspc_pkg::OP_BARRIER: begin
          slot[0] = '{p1 && phase_r != cspc_pkg::PH_RECORD,
                      cspc_pkg::DG_BARRIER_PHASE, cspc_pkg::SEV_ERROR};
          slot[1] = '{p2 && !dev_r, cspc_pkg::DG_BARRIER_HOST, cspc_pkg::SEV_WARN};
          dev_nxt = dev_r || p2;
        end
        cspc_pkg::OP_SUBMIT: begin
          slot[0] = '{p1 && phase_r != cspc_pkg::PH_RECORD,
                      cspc_pkg::DG_SUBMIT_PHASE, cspc_pkg::SEV_ERROR};
          slot[1] = '{p1 && snap_r, cspc_pkg::DG_SUBMIT_SNAP, cspc_pkg::SEV_ERROR};
          phase_nxt = cspc_pkg::PH_SUBMITTED;
          dev_nxt   = 1'b1;
        end
        cspc_pkg::OP_FENCE_WAIT: begin
          slot[0] = '{p1 && phase_r != cspc_pkg::PH_SUBMITTED,
                      cspc_pkg::DG_FENCE_PHASE, cspc_pkg::SEV_ERROR};
          phase_nxt = cspc_pkg::PH_IDLE;
          dev_nxt   = 1'b0;
        end
        cspc_pkg::OP_END_STREAM: begin
          slot[0] = '{p1 && phase_r != cspc_pkg::PH_IDLE && phase_r != cspc_pkg::PH_RECORD,
                      cspc_pkg::DG_ENDSTR_PHASE, cspc_pkg::SEV_ERROR};
          slot[1] = '{p1 && phase_r == cspc_pkg::PH_RECORD,
                      cspc_pkg::DG_ENDSTR_RECORD, cspc_pkg::SEV_WARN};
          phase_nxt   = cspc_pkg::PH_FINISHED;
          seen_se_nxt = 1'b1;
        end
        cspc_pkg::OP_PROG_END: begin
          slot[0] = '{p1 && phase_r != cspc_pkg::PH_FINISHED,
                      cspc_pkg::DG_ENDPRG_PHASE, cspc_pkg::SEV_ERROR};
          slot[1] = '{!stg_last_r, cspc_pkg::DG_ENDPRG_NOTLAST, cspc_pkg::SEV_ERROR};
          seen_pe_nxt = 1'b1;
          if (!stg_last_r) begin
            stopped_nxt = 1'b1;
          end
        end
        cspc_pkg::OP_SNAPSHOT_BEGIN: begin
          slot[0] = '{p2 && snap_r, cspc_pkg::DG_SNAP_NESTED, cspc_pkg::SEV_ERROR};
          slot[1] = '{p2 && phase_r != cspc_pkg::PH_IDLE,
                      cspc_pkg::DG_SNAP_PHASE, cspc_pkg::SEV_ERROR};
          slot[2] = '{p2 && dev_r, cspc_pkg::DG_SNAP_DEVICE, cspc_pkg::SEV_ERROR};
          snap_nxt = 1'b1;
        end
        cspc_pkg::OP_SNAPSHOT_END: begin
          slot[0] = '{p2 && !snap_r, cspc_pkg::DG_SNAPEND_NONE, cspc_pkg::SEV_ERROR};
          snap_nxt = 1'b0;
        end
        cspc_pkg::OP_CHECKPOINT: begin
          slot[0] = '{p2 && phase_r != cspc_pkg::PH_IDLE,
                      cspc_pkg::DG_CKPT_PHASE, cspc_pkg::SEV_ERROR};
        end
        default: begin
        end
      endcase
    end

    // End checks run on the last byte or on an early program end.
    end_run = stopped_nxt || stg_last_r;
    if (end_run) begin
      stopped_nxt = 1'b1;
    end
    slot[3] = '{end_run && snap_nxt, cspc_pkg::DG_UNTERM_SNAP, cspc_pkg::SEV_ERROR};
    if (!seen_pe_nxt) begin
      slot[4] = '{end_run, seen_se_nxt ? cspc_pkg::DG_MISS_ENDPRG : cspc_pkg::DG_MISS_ENDSTR,
                  cspc_pkg::SEV_ERROR};
    end else begin
      slot[4] = '{end_run && phase_nxt != cspc_pkg::PH_FINISHED,
                  cspc_pkg::DG_UNTERM_PROG, cspc_pkg::SEV_ERROR};
    end
  end

  // Diagnostic limit: the first valid slots, up to the remaining limit, are emitted, the rest are dropped.
  always_comb begin
    avail_full = LIMIT_V - emit_cnt_r;
    avail      = (avail_full > EMW'(NS)) ? 3'(NS) : avail_full[2:0];
    rank   = '0;
    n_err  = '0;
    n_warn = '0;
    n_drop = '0;
    for (int k = 0; k < NS; k++) begin
      emit[k] = 1'b0;
      pos[k]  = rank;
      if (slot[k].valid) begin
        if (rank < avail) begin
          emit[k] = 1'b1;
          rank    = rank + 3'd1;
          if (slot[k].sev == cspc_pkg::SEV_WARN) begin
            n_warn = n_warn + 3'd1;
          end else begin
            n_err = n_err + 3'd1;
          end
        end else begin
          n_drop = n_drop + 3'd1;
        end
      end
    end
    nres = rank + (end_run ? 3'd1 : 3'd0);
  end

  // Counter updates.
  always_comb begin
    index_nxt    = cspc_pkg::sat_add16(index_r, 3'd1);
    known_nxt    = cspc_pkg::sat_add16(known_r, {2'b00, known_op});
    err_nxt      = cspc_pkg::sat_add16(err_r, n_err);
    warn_nxt     = cspc_pkg::sat_add16(warn_r, n_warn);
    drop_nxt     = cspc_pkg::sat_add16(drop_r, n_drop);
    emit_cnt_nxt = emit_cnt_r + EMW'(rank);
  end

  // Result records and their queue addresses.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      rec[k]             = '0;
      rec[k].diag_code   = slot[k].code;
      rec[k].severity    = slot[k].sev;
      rec[k].instr_index = (k < cspc_pkg::OP_SLOTS) ? index_r : index_nxt;
      rec[k].phase_seen  = (k < cspc_pkg::OP_SLOTS) ? phase_r : phase_nxt;
      rec[k].last        = (pos[k] == nres - 3'd1);
      waddr[k]           = wptr_r + PW'(pos[k]);
    end
    sum_rec               = '0;
    sum_rec.instr_index   = index_nxt;
    sum_rec.phase_seen    = phase_nxt;
    sum_rec.is_summary    = 1'b1;
    sum_rec.success       = (err_nxt == 16'd0) && (drop_nxt == 16'd0);
    sum_rec.error_total   = err_nxt;
    sum_rec.warning_total = warn_nxt;
    sum_rec.known_count   = known_nxt;
    sum_rec.dropped_total = drop_nxt;
    sum_rec.last          = 1'b1;
    sum_addr              = wptr_r + PW'(rank);
  end

  // Configuration, input register and checker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= cspc_pkg::LVL_FULL;
      stg_v_r    <= 1'b0;
      phase_r    <= cspc_pkg::PH_BUILD;
      dev_r      <= 1'b0;
      snap_r     <= 1'b0;
      seen_se_r  <= 1'b0;
      seen_pe_r  <= 1'b0;
      stopped_r  <= 1'b0;
      index_r    <= '0;
      known_r    <= '0;
      err_r      <= '0;
      warn_r     <= '0;
      emit_cnt_r <= '0;
      drop_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        level_r <= cfg_wr_data;
      end
      stg_v_r <= in_tvalid && in_tready;
      if (proc) begin
        phase_r    <= phase_nxt;
        dev_r      <= dev_nxt;
        snap_r     <= snap_nxt;
        seen_se_r  <= seen_se_nxt;
        seen_pe_r  <= seen_pe_nxt;
        stopped_r  <= stopped_nxt;
        index_r    <= index_nxt;
        known_r    <= known_nxt;
        err_r      <= err_nxt;
        warn_r     <= warn_nxt;
        emit_cnt_r <= emit_cnt_nxt;
        drop_r     <= drop_nxt;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_op_r   <= in_tdata;
      stg_last_r <= in_tlast;
    end
  end

  // Result queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (proc) begin
        wptr_r <= wptr_r + PW'(nres);
      end
      if (pop) begin
        rptr_r <= rptr_r + PW'(1);
      end
      count_r <= count_r + (proc ? CW'(nres) : CW'(0)) - (pop ? CW'(1) : CW'(0));
    end
  end

  // Result queue storage: each burst lands in consecutive entries.
  always_ff @(posedge clk) begin
    if (proc) begin
      for (int k = 0; k < NS; k++) begin
        if (emit[k]) begin
          queue_r[waddr[k]] <= rec[k];
        end
      end
      if (end_run) begin
        queue_r[sum_addr] <= sum_rec;
      end
    end
  end

  // Result channel.
  always_comb begin
    out_tvalid        = count_r != '0;
    out_tdata         = '0;
    out_tdata[4:0]    = queue_r[rptr_r].diag_code;
    out_tdata[5]      = queue_r[rptr_r].severity;
    out_tdata[21:6]   = queue_r[rptr_r].instr_index;
    out_tdata[24:22]  = queue_r[rptr_r].phase_seen;
    out_tdata[25]     = queue_r[rptr_r].success;
    out_tdata[41:26]  = queue_r[rptr_r].error_total;
    out_tdata[57:42]  = queue_r[rptr_r].warning_total;
    out_tdata[73:58]  = queue_r[rptr_r].known_count;
    out_tdata[89:74]  = queue_r[rptr_r].dropped_total;
    out_tuser         = queue_r[rptr_r].is_summary;
    out_tlast         = queue_r[rptr_r].last;
  end

endmodule

`default_nettype wire

[tb/cspc_order_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command order checker
// Watches the configuration port and both streams of the phase checker. It
// keeps its own copy of the phase, domain, snapshot and counter state,
// predicts the diagnostics and the summary for every accepted command
// request, and compares each result request field by field.
// ----------------------------------------------------------------------------
module cspc_order_checker #(
  parameter int DIAG_LIMIT = cspc_pkg::DIAG_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  // Failures so far, and result requests still awaited.
  output int          fail_count,
  output int          awaited
);

  localparam int MAX_REPORTS = 10;

  // Shadow of the block state.
  logic [1:0]  check_lvl;
  logic [2:0]  cur_phase;
  logic        device_dom;
  logic        snap_open;
  logic        stream_ended;
  logic        program_ended;
  logic        halted;
  logic [15:0] byte_index;
  logic [15:0] known_cnt;
  logic [15:0] err_cnt;
  logic [15:0] warn_cnt;
  int          emitted_cnt;
  logic [15:0] dropped_cnt;

  cspc_pkg::res_t byte_results[$];
  cspc_pkg::res_t pending_results[$];
  int             errors_seen = 0;
  int             results_seen = 0;

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Emits one diagnostic unless the limit is reached, in which case it is
  // only counted as dropped.
  function automatic void raise_diag(input logic [4:0] code, input logic sev,
                                     input logic [15:0] idx);
    cspc_pkg::res_t r;
    if (emitted_cnt >= DIAG_LIMIT) begin
      dropped_cnt = bump16(dropped_cnt);
      return;
    end
    emitted_cnt++;
    if (sev == cspc_pkg::SEV_WARN) warn_cnt = bump16(warn_cnt);
    else err_cnt = bump16(err_cnt);
    r = '0;
    r.diag_code   = code;
    r.severity    = sev;
    r.instr_index = idx;
    r.phase_seen  = cur_phase;
    byte_results.push_back(r);
  endfunction

  // Applies one command byte to the shadow state and queues its results.
  function automatic void predict_command(input logic [7:0] op, input logic fin);
    logic           p1;
    logic           p2;
    logic [15:0]    idx;
    cspc_pkg::res_t s;
    if (halted) return;
    byte_results.delete();
    p1  = (check_lvl >= cspc_pkg::LVL_PHASE);
    p2  = (check_lvl >= cspc_pkg::LVL_FULL);
    idx = byte_index;

    if (op > cspc_pkg::OP_CHECKPOINT) begin
      raise_diag(cspc_pkg::DG_UNKNOWN_OP, cspc_pkg::SEV_ERROR, idx);
    end else begin
      known_cnt = bump16(known_cnt);
      case (op)
        cspc_pkg::OP_BEGIN_STREAM: begin
          if (p1) begin
            if (snap_open) raise_diag(cspc_pkg::DG_BEGIN_SNAP, cspc_pkg::SEV_ERROR, idx);
            if (cur_phase != cspc_pkg::PH_BUILD && cur_phase != cspc_pkg::PH_IDLE)
              raise_diag(cspc_pkg::DG_BEGIN_PHASE, cspc_pkg::SEV_ERROR, idx);
          end
          cur_phase = cspc_pkg::PH_RECORD;
        end
        cspc_pkg::OP_BARRIER: begin
          if (p1 && cur_phase != cspc_pkg::PH_RECORD)
            raise_diag(cspc_pkg::DG_BARRIER_PHASE, cspc_pkg::SEV_ERROR, idx);
          // The move to the device domain rides on the level-2 check.
          if (p2 && !device_dom) begin
            raise_diag(cspc_pkg::DG_BARRIER_HOST, cspc_pkg::SEV_WARN, idx);
            device_dom = 1'b1;
          end
        end
        cspc_pkg::OP_SUBMIT: begin
          if (p1) begin
            if (cur_phase != cspc_pkg::PH_RECORD)
              raise_diag(cspc_pkg::DG_SUBMIT_PHASE, cspc_pkg::SEV_ERROR, idx);
            if (snap_open) raise_diag(cspc_pkg::DG_SUBMIT_SNAP, cspc_pkg::SEV_ERROR, idx);
          end
          cur_phase  = cspc_pkg::PH_SUBMITTED;
          device_dom = 1'b1;
        end
        cspc_pkg::OP_FENCE_WAIT: begin
          if (p1 && cur_phase != cspc_pkg::PH_SUBMITTED)
            raise_diag(cspc_pkg::DG_FENCE_PHASE, cspc_pkg::SEV_ERROR, idx);
          cur_phase  = cspc_pkg::PH_IDLE;
          device_dom = 1'b0;
        end
        cspc_pkg::OP_END_STREAM: begin
          if (p1 && cur_phase != cspc_pkg::PH_IDLE && cur_phase != cspc_pkg::PH_RECORD)
            raise_diag(cspc_pkg::DG_ENDSTR_PHASE, cspc_pkg::SEV_ERROR, idx);
          if (p1 && cur_phase == cspc_pkg::PH_RECORD)
            raise_diag(cspc_pkg::DG_ENDSTR_RECORD, cspc_pkg::SEV_WARN, idx);
          cur_phase    = cspc_pkg::PH_FINISHED;
          stream_ended = 1'b1;
        end
        cspc_pkg::OP_PROG_END: begin
          program_ended = 1'b1;
          if (p1 && cur_phase != cspc_pkg::PH_FINISHED)
            raise_diag(cspc_pkg::DG_ENDPRG_PHASE, cspc_pkg::SEV_ERROR, idx);
          // Bytes still follow, so the stream stops here.
          if (!fin) begin
            raise_diag(cspc_pkg::DG_ENDPRG_NOTLAST, cspc_pkg::SEV_ERROR, idx);
            halted = 1'b1;
          end
        end
        cspc_pkg::OP_SNAPSHOT_BEGIN: begin
          if (p2) begin
            if (snap_open) raise_diag(cspc_pkg::DG_SNAP_NESTED, cspc_pkg::SEV_ERROR, idx);
            if (cur_phase != cspc_pkg::PH_IDLE)
              raise_diag(cspc_pkg::DG_SNAP_PHASE, cspc_pkg::SEV_ERROR, idx);
            if (device_dom) raise_diag(cspc_pkg::DG_SNAP_DEVICE, cspc_pkg::SEV_ERROR, idx);
          end
          snap_open = 1'b1;
        end
        cspc_pkg::OP_SNAPSHOT_END: begin
          if (p2 && !snap_open)
            raise_diag(cspc_pkg::DG_SNAPEND_NONE, cspc_pkg::SEV_ERROR, idx);
          snap_open = 1'b0;
        end
        cspc_pkg::OP_CHECKPOINT: begin
          if (p2 && cur_phase != cspc_pkg::PH_IDLE)
            raise_diag(cspc_pkg::DG_CKPT_PHASE, cspc_pkg::SEV_ERROR, idx);
        end
        default: begin
        end
      endcase
    end
    byte_index = bump16(byte_index);

    // End of stream: closing checks, then the summary.
    if (halted || fin) begin
      idx    = byte_index;
      halted = 1'b1;
      if (snap_open) raise_diag(cspc_pkg::DG_UNTERM_SNAP, cspc_pkg::SEV_ERROR, idx);
      if (!program_ended)
        raise_diag(stream_ended ? cspc_pkg::DG_MISS_ENDPRG : cspc_pkg::DG_MISS_ENDSTR,
                   cspc_pkg::SEV_ERROR, idx);
      else if (cur_phase != cspc_pkg::PH_FINISHED)
        raise_diag(cspc_pkg::DG_UNTERM_PROG, cspc_pkg::SEV_ERROR, idx);
      s = '0;
      s.instr_index   = idx;
      s.phase_seen    = cur_phase;
      s.is_summary    = 1'b1;
      s.success       = (err_cnt == 16'd0 && dropped_cnt == 16'd0);
      s.error_total   = err_cnt;
      s.warning_total = warn_cnt;
      s.known_count   = known_cnt;
      s.dropped_total = dropped_cnt;
      byte_results.push_back(s);
    end

    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
  endfunction

  function automatic string show(input cspc_pkg::res_t r);
    return $sformatf({"code=%0d sev=%0d idx=%0d phase=%0d summary=%0d ok=%0d",
                      " err=%0d warn=%0d known=%0d drop=%0d last=%0d"},
                     r.diag_code, r.severity, r.instr_index, r.phase_seen,
                     r.is_summary, r.success, r.error_total, r.warning_total,
                     r.known_count, r.dropped_total, r.last);
  endfunction

  function automatic void note_failure(input string msg);
    errors_seen++;
    if (errors_seen <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Compares one accepted result request with the oldest expectation.
  task automatic check_result();
    cspc_pkg::res_t got;
    cspc_pkg::res_t want;
    string          bad;
    got.diag_code     = out_tdata[4:0];
    got.severity      = out_tdata[5];
    got.instr_index   = out_tdata[21:6];
    got.phase_seen    = out_tdata[24:22];
    got.success       = out_tdata[25];
    got.error_total   = out_tdata[41:26];
    got.warning_total = out_tdata[57:42];
    got.known_count   = out_tdata[73:58];
    got.dropped_total = out_tdata[89:74];
    got.is_summary    = out_tuser;
    got.last          = out_tlast;
    results_seen++;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("%0t: result %0d arrived with nothing expected: %s",
                             $realtime, results_seen, show(got)));
      return;
    end
    want = pending_results.pop_front();
    bad  = "";
    if (got.diag_code !== want.diag_code) bad = {bad, " diag_code"};
    if (got.severity !== want.severity) bad = {bad, " severity"};
    if (got.instr_index !== want.instr_index) bad = {bad, " instr_index"};
    if (got.phase_seen !== want.phase_seen) bad = {bad, " phase_seen"};
    if (got.is_summary !== want.is_summary) bad = {bad, " is_summary"};
    if (got.success !== want.success) bad = {bad, " success"};
    if (got.error_total !== want.error_total) bad = {bad, " error_total"};
    if (got.warning_total !== want.warning_total) bad = {bad, " warning_total"};
    if (got.known_count !== want.known_count) bad = {bad, " known_count"};
    if (got.dropped_total !== want.dropped_total) bad = {bad, " dropped_total"};
    if (got.last !== want.last) bad = {bad, " last"};
    if (out_tdata[95:90] !== 6'd0) bad = {bad, " fill"};
    if (bad != "")
      note_failure($sformatf("%0t: result %0d wrong in%s\n  expected %s\n  actual   %s",
                             $realtime, results_seen, bad, show(want), show(got)));
  endtask

  // Model update and comparison, all on the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      check_lvl     = cspc_pkg::LVL_FULL;
      cur_phase     = cspc_pkg::PH_BUILD;
      device_dom    = 1'b0;
      snap_open     = 1'b0;
      stream_ended  = 1'b0;
      program_ended = 1'b0;
      halted        = 1'b0;
      byte_index    = '0;
      known_cnt     = '0;
      err_cnt       = '0;
      warn_cnt      = '0;
      emitted_cnt   = 0;
      dropped_cnt   = '0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) check_lvl = cfg_wr_data;
      if (in_tvalid && in_tready) predict_command(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    awaited    <= pending_results.size();
    fail_count <= errors_seen;
  end

endmodule

[tb/command_stream_phase_checker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command stream phase checker testbench
// Drives command bytes through the phase checker: an opening run that hits every
// opcode but the program end and most diagnostics, random command sessions at each
// check level, a checkpoint run outside the idle phase, and one stream ending. The
// order checker beside the block predicts and compares every result request.
// ----------------------------------------------------------------------------
module command_stream_phase_checker_tb;

  // Out-of-range check level, handled as the full level.
  localparam logic [1:0] LVL_OVER = 2'd3;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int HOLD_OFF_CYCLES  = 300;
  localparam int SAT_RUN_LEN      = 20;
  localparam int DRAIN_CYCLES     = 20;
  localparam int SETTLE_CYCLES    = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = cspc_pkg::LVL_FULL;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = cspc_pkg::OP_NOP;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b1;
  wire         in_tready;
  wire         out_tvalid;
  wire  [95:0] out_tdata;
  wire         out_tuser;
  wire         out_tlast;
  int          fail_count;
  int          awaited;

  int          src_gap_pct = 0;
  int          sink_stall_pct = 0;
  bit          hold_off_req = 1'b0;
  int          random_sent = 0;
  logic [7:0]  opening_ops[$];

  command_stream_phase_checker i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  cspc_order_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .fail_count  (fail_count),
    .awaited     (awaited)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("command_stream_phase_checker_tb: done, errors");
    $finish;
  end

  // Offers one command request, after an optional gap, and returns on the
  // edge where it is taken.
  task automatic send_cmd(input logic [7:0] op, input logic fin);
    int gap;
    if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= op;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Any byte except the program end, which would stop the stream early.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == cspc_pkg::OP_PROG_END) ? cspc_pkg::OP_NOP : b;
  endfunction

  task automatic put(input logic [7:0] op, input int noise_pct);
    logic [7:0] b;
    b = op;
    if ($urandom_range(0, 99) < noise_pct) b = noise_byte();
    send_cmd(b, 1'b0);
    random_sent++;
  endtask

  // One well-formed record/submit/fence round, with bytes swapped for noise.
  task automatic run_session(input int noise_pct);
    int n;
    put(cspc_pkg::OP_BEGIN_STREAM, noise_pct);
    n = $urandom_range(0, 3);
    repeat (n)
      put(($urandom_range(0, 1) != 0) ? cspc_pkg::OP_BARRIER : cspc_pkg::OP_NOP, noise_pct);
    put(cspc_pkg::OP_SUBMIT, noise_pct);
    put(cspc_pkg::OP_FENCE_WAIT, noise_pct);
    if ($urandom_range(0, 99) < 40) begin
      put(cspc_pkg::OP_SNAPSHOT_BEGIN, noise_pct);
      repeat ($urandom_range(0, 2)) put(cspc_pkg::OP_CHECKPOINT, noise_pct);
      put(cspc_pkg::OP_SNAPSHOT_END, noise_pct);
    end
    if ($urandom_range(0, 1) != 0) put(cspc_pkg::OP_CHECKPOINT, noise_pct);
    if ($urandom_range(0, 99) < 10) put(cspc_pkg::OP_END_STREAM, noise_pct);
  endtask

  task automatic run_sessions(input int n_items, input int noise_pct);
    int start;
    start = random_sent;
    while (random_sent - start < n_items) run_session(noise_pct);
  endtask

  // Waits for the block to drain, then writes the check level.
  task automatic set_level(input logic [1:0] lvl);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One of several ways to end the stream, picked at random.
  task automatic finish_stream();
    case ($urandom_range(0, 4))
      0: begin
        send_cmd(cspc_pkg::OP_END_STREAM, 1'b0);
        send_cmd(cspc_pkg::OP_PROG_END, 1'b1);
      end
      1: send_cmd(cspc_pkg::OP_PROG_END, 1'b0);
      2: begin
        send_cmd(cspc_pkg::OP_SNAPSHOT_BEGIN, 1'b0);
        send_cmd(cspc_pkg::OP_NOP, 1'b1);
      end
      3: begin
        send_cmd(cspc_pkg::OP_END_STREAM, 1'b0);
        send_cmd(cspc_pkg::OP_CHECKPOINT, 1'b1);
      end
      default: send_cmd(cspc_pkg::OP_PROG_END, 1'b1);
    endcase
  endtask

  initial begin
    opening_ops = '{8'hFF, 8'h0A, cspc_pkg::OP_NOP, cspc_pkg::OP_BARRIER,
                    cspc_pkg::OP_SNAPSHOT_BEGIN, cspc_pkg::OP_SNAPSHOT_BEGIN,
                    cspc_pkg::OP_BEGIN_STREAM, cspc_pkg::OP_SUBMIT,
                    cspc_pkg::OP_BEGIN_STREAM, cspc_pkg::OP_SNAPSHOT_END,
                    cspc_pkg::OP_SNAPSHOT_END, cspc_pkg::OP_CHECKPOINT,
                    cspc_pkg::OP_FENCE_WAIT, cspc_pkg::OP_SNAPSHOT_BEGIN,
                    cspc_pkg::OP_CHECKPOINT, cspc_pkg::OP_SNAPSHOT_END,
                    cspc_pkg::OP_BARRIER, cspc_pkg::OP_SUBMIT, cspc_pkg::OP_END_STREAM,
                    cspc_pkg::OP_BARRIER, cspc_pkg::OP_BEGIN_STREAM,
                    cspc_pkg::OP_END_STREAM, cspc_pkg::OP_FENCE_WAIT,
                    cspc_pkg::OP_BEGIN_STREAM, cspc_pkg::OP_BARRIER};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening run at the reset level: every opcode but the program end, and most diagnostics.
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    foreach (opening_ops[i]) send_cmd(opening_ops[i], 1'b0);

    // Phase checks only. The result side holds off while noise fills the queue.
    set_level(cspc_pkg::LVL_PHASE);
    src_gap_pct    = 25;
    sink_stall_pct = 30;
    hold_off_req   = 1'b1;
    repeat (30) put(noise_byte(), 0);
    run_sessions(50, 30);

    // Syntax only, with no idling on either side.
    set_level(cspc_pkg::LVL_SYNTAX);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    run_sessions(60, 20);

    set_level(LVL_OVER);
    src_gap_pct    = 40;
    sink_stall_pct = 10;
    run_sessions(60, 15);

    set_level(cspc_pkg::LVL_FULL);
    src_gap_pct    = 10;
    sink_stall_pct = 50;
    run_sessions(60, 15);

    // Last part, no idling: a checkpoint run outside the idle phase, with a
    // few unknown bytes mixed in, then one stream ending.
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    send_cmd(cspc_pkg::OP_BEGIN_STREAM, 1'b0);
    repeat (SAT_RUN_LEN)
      send_cmd(($urandom_range(0, 31) == 0) ? 8'($urandom_range(10, 255))
                                            : cspc_pkg::OP_CHECKPOINT,
               1'b0);
    finish_stream();

    // Bytes after the stop must be ignored.
    repeat (3) send_cmd(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("command_stream_phase_checker_tb: done, clean");
    else
      $display("command_stream_phase_checker_tb: done, errors");
    $finish;
  end

endmodule
